### design/bfse_pkg.sv
`default_nettype none

package bfse_pkg;

   // Kind of video memory read issued on a dot.
   typedef enum logic [1:0] {
      FETCH_NONE      = 2'd0,
      FETCH_NAMETABLE = 2'd1,
      FETCH_ATTRIBUTE = 2'd2,
      FETCH_PATTERN   = 2'd3
   } fetch_kind_type;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG_ENABLE            = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG_LEFT_ENABLE       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HALF         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VBLANK_NMI_ENABLE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FINE_X_SCROLL        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCROLL_TEMP_ADDRESS  = 3'd5;
   localparam int unsigned CSR_DATA_W = 15;

   // Video timing. Lines are stored offset by one so that the prerender line is zero.
   localparam logic [8:0] DOTS_LAST        = 9'd340;
   localparam logic [8:0] LINE_PRERENDER   = 9'd0;
   localparam logic [8:0] LINE_FIRST_SHOWN = 9'd1;
   localparam logic [8:0] LINE_LAST_SHOWN  = 9'd240;
   localparam logic [8:0] LINE_VBLANK      = 9'd242;
   localparam logic [8:0] LINE_LAST        = 9'd261;

   // Scroll address field masks.
   localparam logic [14:0] HORIZ_COPY_MASK = 15'h041f;
   localparam logic [14:0] VERT_COPY_MASK  = 15'h7be0;

   // Configuration as seen by the engine.
   typedef struct packed {
      logic        bg_enable;
      logic        bg_left_enable;
      logic        background_pattern_half;
      logic        vblank_nmi_enable;
      logic [2:0]  fine_x_scroll;
      logic [14:0] scroll_temp_address;
   } cfg_type;

   // One result item.
   typedef struct packed {
      fetch_kind_type fetch_kind;
      logic [13:0]    fetch_address;
      logic           pixel_valid;
      logic [7:0]     pixel_x;
      logic [7:0]     pixel_y;
      logic [3:0]     palette_index;
      logic           vblank;
      logic           nmi_request;
   } rsp_type;

endpackage

`default_nettype wire

### design/background_fetch_scroll_engine.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  read_data
// rsp_      out        rsp_valid / rsp_stall  fetch and pixel fields, vblank, nmi_request
// csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// While req_stall is low, one item per clock: the dot logic runs between the timing state
// registers and the result register, so an item's result appears the cycle after acceptance.
// Reset puts the timing at dot 0 of the prerender line, clearing all but the result data.
// The result register holds its item while rsp_stall is high; req_stall is raised
// only while that register is full and stalled. csr writes are always ready.
module background_fetch_scroll_engine (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [7:0]                      req_read_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [1:0]                           rsp_fetch_kind,
   output logic [13:0]                          rsp_fetch_address,
   output logic                                 rsp_pixel_valid,
   output logic [7:0]                           rsp_pixel_x,
   output logic [7:0]                           rsp_pixel_y,
   output logic [3:0]                           rsp_palette_index,
   output logic                                 rsp_vblank,
   output logic                                 rsp_nmi_request,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [bfse_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bfse_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bfse_pkg::*;

   cfg_type cfg_ff;
   rsp_type step_rsp;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    accept;

   // Configuration registers; unknown indexes are ignored.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BG_ENABLE:            cfg_ff.bg_enable               <= csr_data[0];
            CSR_BG_LEFT_ENABLE:       cfg_ff.bg_left_enable          <= csr_data[0];
            CSR_PATTERN_HALF:         cfg_ff.background_pattern_half <= csr_data[0];
            CSR_VBLANK_NMI_ENABLE:    cfg_ff.vblank_nmi_enable       <= csr_data[0];
            CSR_FINE_X_SCROLL:        cfg_ff.fine_x_scroll           <= csr_data[2:0];
            CSR_SCROLL_TEMP_ADDRESS:  cfg_ff.scroll_temp_address     <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // An item is taken whenever the result register is free or being emptied.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   bfse_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step_en   (accept),
      .read_data (req_read_data),
      .cfg       (cfg_ff),
      .rsp       (step_rsp)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fetch_kind    = rsp_ff.fetch_kind;
   assign rsp_fetch_address = rsp_ff.fetch_address;
   assign rsp_pixel_valid   = rsp_ff.pixel_valid;
   assign rsp_pixel_x       = rsp_ff.pixel_x;
   assign rsp_pixel_y       = rsp_ff.pixel_y;
   assign rsp_palette_index = rsp_ff.palette_index;
   assign rsp_vblank        = rsp_ff.vblank;
   assign rsp_nmi_request   = rsp_ff.nmi_request;

endmodule

`default_nettype wire

### design/bfse_engine.sv
`default_nettype none

module bfse_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire logic [7:0]       read_data,
   input  wire bfse_pkg::cfg_type cfg,
   output bfse_pkg::rsp_type     rsp
);
   import bfse_pkg::*;

   // Timing, scroll and pipeline state.
   logic [8:0]     dot_ff, dot_in;
   logic [8:0]     line_ff, line_in;
   logic           odd_ff, odd_in;
   logic [14:0]    va_ff, va_in;
   logic [7:0]     tile_ff, tile_in;
   logic [7:0]     plo_ff, plo_in;
   logic [7:0]     phi_ff, phi_in;
   logic [1:0]     attr_ff, attr_in;
   logic [15:0]    pat_lo_ff, pat_lo_in;
   logic [15:0]    pat_hi_ff, pat_hi_in;
   logic [15:0]    att_lo_ff, att_lo_in;
   logic [15:0]    att_hi_ff, att_hi_in;
   fetch_kind_type pend_kind_ff, pend_kind_in;
   logic [1:0]     pend_quad_ff, pend_quad_in;
   logic           vblank_ff, vblank_in;

   // Coarse X increment with horizontal nametable wrap.
   function automatic logic [14:0] step_x(input logic [14:0] va);
      logic [14:0] r;
      if (va[4:0] == 5'd31) begin
         r = {va[14:11], ~va[10], va[9:5], 5'd0};
      end else begin
         r = va + 15'd1;
      end
      return r;
   endfunction

   // Fine Y increment, carrying into coarse Y with vertical nametable wrap.
   function automatic logic [14:0] step_y(input logic [14:0] va);
      logic [14:0] r;
      if (va[14:12] != 3'd7) begin
         r = {va[14:12] + 3'd1, va[11:0]};
      end else if (va[9:5] == 5'd29) begin
         r = {3'd0, ~va[11], va[10], 5'd0, va[4:0]};
      end else begin
         r = {3'd0, va[11:10], va[9:5] + 5'd1, va[4:0]};
      end
      return r;
   endfunction

   // Per-dot work: finish the last fetch, run this dot's events, form the pixel, advance the counters.
   always_comb begin
      logic [2:0] phase;
      logic       render_dot;
      logic [3:0] sel;
      logic [1:0] pat;
      logic [1:0] pal;

      dot_in       = dot_ff;
      line_in      = line_ff;
      odd_in       = odd_ff;
      va_in        = va_ff;
      tile_in      = tile_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      attr_in      = attr_ff;
      pat_lo_in    = pat_lo_ff;
      pat_hi_in    = pat_hi_ff;
      att_lo_in    = att_lo_ff;
      att_hi_in    = att_hi_ff;
      pend_quad_in = pend_quad_ff;
      vblank_in    = vblank_ff;
      rsp          = '0;
      rsp.fetch_kind = FETCH_NONE;

      phase      = dot_ff[2:0] - 3'd1;
      render_dot = (dot_ff >= 9'd2 && dot_ff <= 9'd257) ||
                   (dot_ff >= 9'd321 && dot_ff <= 9'd337);

      // Complete the fetch issued on the previous dot.
      case (pend_kind_ff)
         FETCH_NAMETABLE: tile_in = read_data;
         FETCH_ATTRIBUTE: begin
            case (pend_quad_ff)
               2'd0:    attr_in = read_data[1:0];
               2'd1:    attr_in = read_data[3:2];
               2'd2:    attr_in = read_data[5:4];
               default: attr_in = read_data[7:6];
            endcase
         end
         FETCH_PATTERN: begin
            if (pend_quad_ff[0]) begin
               phi_in = read_data;
            end else begin
               plo_in = read_data;
            end
         end
         default: ;
      endcase

      // Events of this dot.
      if ((line_ff == LINE_VBLANK || line_ff == LINE_PRERENDER) && dot_ff == 9'd1) begin
         if (line_ff == LINE_PRERENDER) begin
            vblank_in = 1'b0;
         end else begin
            vblank_in       = 1'b1;
            rsp.nmi_request = cfg.vblank_nmi_enable;
         end
      end else if (line_ff == LINE_FIRST_SHOWN && dot_ff == 9'd0) begin
         // Odd frames drop the first idle dot of the first visible line.
         if (odd_ff) begin
            dot_in = 9'd1;
         end
         odd_in = ~odd_ff;
      end else if (line_ff <= LINE_LAST_SHOWN) begin
         if (render_dot) begin
            if (cfg.bg_enable) begin
               pat_lo_in = {pat_lo_ff[14:0], 1'b0};
               pat_hi_in = {pat_hi_ff[14:0], 1'b0};
               att_lo_in = {att_lo_ff[14:0], 1'b0};
               att_hi_in = {att_hi_ff[14:0], 1'b0};
            end
            // Reload the low byte of the shifters at the start of each tile.
            if (phase == 3'd0) begin
               pat_lo_in[7:0] = plo_in;
               pat_hi_in[7:0] = phi_in;
               att_lo_in[7:0] = {8{attr_in[0]}};
               att_hi_in[7:0] = {8{attr_in[1]}};
            end
            case (phase)
               3'd0: begin
                  rsp.fetch_kind    = FETCH_NAMETABLE;
                  rsp.fetch_address = {2'b10, va_ff[11:0]};
               end
               3'd2: begin
                  rsp.fetch_kind    = FETCH_ATTRIBUTE;
                  rsp.fetch_address = {2'b10, va_ff[11:10], 4'b1111, va_ff[9:7], va_ff[4:2]};
                  pend_quad_in      = {va_ff[6], va_ff[1]};
               end
               3'd4, 3'd6: begin
                  rsp.fetch_kind    = FETCH_PATTERN;
                  rsp.fetch_address = {1'b0, cfg.background_pattern_half, tile_in,
                                       phase[1], va_ff[14:12]};
                  pend_quad_in      = {1'b0, phase[1]};
               end
               3'd7: begin
                  if (cfg.bg_enable) begin
                     va_in = step_x(va_ff);
                  end
               end
               default: ;
            endcase
            // End of the visible row: next row, then horizontal scroll reload.
            if (dot_ff == 9'd256) begin
               if (cfg.bg_enable) begin
                  va_in = step_y(va_in);
               end
            end else if (dot_ff == 9'd257) begin
               if (cfg.bg_enable) begin
                  va_in = (va_in & ~HORIZ_COPY_MASK) |
                          (cfg.scroll_temp_address & HORIZ_COPY_MASK);
               end
            end
         end else if (line_ff == LINE_PRERENDER && dot_ff >= 9'd280 && dot_ff <= 9'd304) begin
            if (cfg.bg_enable) begin
               va_in = (va_in & ~VERT_COPY_MASK) | (cfg.scroll_temp_address & VERT_COPY_MASK);
            end
         end
      end
      pend_kind_in = rsp.fetch_kind;

      // Pixel from the shifters, tapped by fine X.
      sel = {1'b1, ~cfg.fine_x_scroll};
      pat = {pat_hi_in[sel], pat_lo_in[sel]};
      pal = {att_hi_in[sel], att_lo_in[sel]};
      if (line_ff >= LINE_FIRST_SHOWN && line_ff <= LINE_LAST_SHOWN &&
          dot_in >= 9'd1 && dot_in <= 9'd256 &&
          (cfg.bg_left_enable || dot_in > 9'd8)) begin
         rsp.pixel_valid = 1'b1;
         rsp.pixel_x     = 8'(dot_in - 9'd1);
         rsp.pixel_y     = 8'(line_ff - 9'd1);
         if (cfg.bg_enable && pat != 2'd0) begin
            rsp.palette_index = {pal, pat};
         end
      end
      rsp.vblank = vblank_in;

      // Advance the dot and line counters.
      if (dot_in >= DOTS_LAST) begin
         dot_in = 9'd0;
         if (line_ff >= LINE_LAST) begin
            line_in = LINE_PRERENDER;
         end else begin
            line_in = line_ff + 9'd1;
         end
      end else begin
         dot_in = dot_in + 9'd1;
      end
   end

   // State update on each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff       <= 9'd0;
         line_ff      <= LINE_PRERENDER;
         odd_ff       <= 1'b0;
         va_ff        <= '0;
         tile_ff      <= '0;
         plo_ff       <= '0;
         phi_ff       <= '0;
         attr_ff      <= '0;
         pat_lo_ff    <= '0;
         pat_hi_ff    <= '0;
         att_lo_ff    <= '0;
         att_hi_ff    <= '0;
         pend_kind_ff <= FETCH_NONE;
         pend_quad_ff <= '0;
         vblank_ff    <= 1'b0;
      end else if (step_en) begin
         dot_ff       <= dot_in;
         line_ff      <= line_in;
         odd_ff       <= odd_in;
         va_ff        <= va_in;
         tile_ff      <= tile_in;
         plo_ff       <= plo_in;
         phi_ff       <= phi_in;
         attr_ff      <= attr_in;
         pat_lo_ff    <= pat_lo_in;
         pat_hi_ff    <= pat_hi_in;
         att_lo_ff    <= att_lo_in;
         att_hi_ff    <= att_hi_in;
         pend_kind_ff <= pend_kind_in;
         pend_quad_ff <= pend_quad_in;
         vblank_ff    <= vblank_in;
      end
   end

endmodule

`default_nettype wire
